[src/dvf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvf_pkg
// Types, codes and constants shared by the viewport fit pipeline.
// ----------------------------------------------------------------------------
package dvf_pkg;

    localparam logic [15:0] DEFAULT_W = 16'd1280;
    localparam logic [15:0] DEFAULT_H = 16'd720;

    localparam logic [2:0] MODE_STRETCH = 3'd0;
    localparam logic [2:0] MODE_NATIVE  = 3'd1;
    localparam logic [2:0] MODE_INTEGER = 3'd2;
    localparam logic [2:0] MODE_FIT     = 3'd3;
    localparam logic [2:0] MODE_CUSTOM  = 3'd4;

    localparam logic [2:0] ASP_SOURCE = 3'd0;
    localparam logic [2:0] ASP_16_9   = 3'd1;
    localparam logic [2:0] ASP_4_3    = 3'd2;
    localparam logic [2:0] ASP_3_2    = 3'd3;
    localparam logic [2:0] ASP_1_1    = 3'd4;
    localparam logic [2:0] ASP_10_9   = 3'd5;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_ASPECT = 1'b1;

    localparam int AQ_W = 33;
    localparam int AD_W = 17;
    localparam int BQ_W = 32;
    localparam int BD_W = 16;

    typedef struct packed {
        logic [15:0] source_width;
        logic [15:0] source_height;
        logic [15:0] display_width;
        logic [15:0] display_height;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic [15:0]        view_width;
        logic [15:0]        view_height;
        logic [31:0]        scale_x;
        logic [31:0]        scale_y;
        logic               keep_previous;
    } out_word_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        wide;
        logic [15:0] sw;
        logic [15:0] sh;
        logic [15:0] dw;
        logic [15:0] dh;
    } front_ctx_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] dw;
        logic [15:0] dh;
        logic [15:0] vw;
        logic [15:0] vh;
    } back_ctx_t;

endpackage

[src/dvf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module dvf_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [NUM_W-1:0]  vld_reg;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0]  num_prev;
        logic [DEN_W-1:0]  rem_prev;
        logic [DEN_W-1:0]  den_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              vld_prev;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W:0]    diff;

        if (k == 0) begin : g_first
            assign num_prev  = in_num;
            assign rem_prev  = '0;
            assign den_prev  = in_den;
            assign side_prev = in_side;
            assign vld_prev  = in_valid;
        end else begin : g_next
            assign num_prev  = num_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        assign trial = {rem_prev, num_prev[NUM_W-1]};
        assign ge    = trial >= {1'b0, den_prev};
        assign diff  = ge ? trial - {1'b0, den_prev} : trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                num_reg[k]  <= {num_prev[NUM_W-2:0], ge};
                rem_reg[k]  <= diff[DEN_W-1:0];
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quot  = num_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

[src/dvf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvf_front
// Default sizes, target aspect, cross products and first divider operands.
// ----------------------------------------------------------------------------
module dvf_front import dvf_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  in_word_t        in_word,
    input  logic [2:0]      mode,
    input  logic [2:0]      aspect,
    output logic            out_valid,
    output front_ctx_t      out_ctx,
    output logic [AQ_W-1:0] ax_num,
    output logic [AD_W-1:0] ax_den,
    output logic [AQ_W-1:0] ay_num,
    output logic [AD_W-1:0] ay_den
);

    logic [15:0] sw_next, sh_next, dw_next, dh_next, num_next, den_next;
    logic        v0_reg, v1_reg, v2_reg;
    front_ctx_t  c0_reg, c1_reg, c2_reg;
    logic [15:0] num0_reg, den0_reg, num1_reg, den1_reg;
    logic [31:0] pw_reg, ph_reg;
    logic [AQ_W-1:0] axn_reg, ayn_reg, axn_next, ayn_next;
    logic [AD_W-1:0] axd_reg, ayd_reg, axd_next, ayd_next;
    logic        wide_next;

    always_comb begin
        sw_next = (in_word.source_width   == '0) ? DEFAULT_W : in_word.source_width;
        sh_next = (in_word.source_height  == '0) ? DEFAULT_H : in_word.source_height;
        dw_next = (in_word.display_width  == '0) ? DEFAULT_W : in_word.display_width;
        dh_next = (in_word.display_height == '0) ? DEFAULT_H : in_word.display_height;
        case (aspect)
            ASP_16_9: begin num_next = 16'd16; den_next = 16'd9; end
            ASP_4_3:  begin num_next = 16'd4;  den_next = 16'd3; end
            ASP_3_2:  begin num_next = 16'd3;  den_next = 16'd2; end
            ASP_1_1:  begin num_next = 16'd1;  den_next = 16'd1; end
            ASP_10_9: begin num_next = 16'd10; den_next = 16'd9; end
            default:  begin num_next = sw_next; den_next = sh_next; end
        endcase
    end

    always_comb begin
        wide_next = pw_reg > ph_reg;
        axn_next  = {{(AQ_W-16){1'b0}}, c1_reg.dw};
        axd_next  = {1'b0, c1_reg.sw};
        ayn_next  = {{(AQ_W-16){1'b0}}, c1_reg.dh};
        ayd_next  = {1'b0, c1_reg.sh};
        if (c1_reg.mode == MODE_FIT) begin
            if (wide_next) begin
                axn_next = {ph_reg, 1'b0} + {17'd0, den1_reg};
                axd_next = {den1_reg, 1'b0};
            end else begin
                ayn_next = {pw_reg, 1'b0} + {17'd0, num1_reg};
                ayd_next = {num1_reg, 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (ce) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c0_reg      <= '{mode: mode, wide: 1'b0, sw: sw_next, sh: sh_next,
                             dw: dw_next, dh: dh_next};
            num0_reg    <= num_next;
            den0_reg    <= den_next;
            c1_reg      <= c0_reg;
            num1_reg    <= num0_reg;
            den1_reg    <= den0_reg;
            pw_reg      <= c0_reg.dw * den0_reg;
            ph_reg      <= c0_reg.dh * num0_reg;
            c2_reg      <= '{mode: c1_reg.mode, wide: wide_next, sw: c1_reg.sw,
                             sh: c1_reg.sh, dw: c1_reg.dw, dh: c1_reg.dh};
            axn_reg     <= axn_next;
            axd_reg     <= axd_next;
            ayn_reg     <= ayn_next;
            ayd_reg     <= ayd_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_ctx   = c2_reg;
    assign ax_num    = axn_reg;
    assign ax_den    = axd_reg;
    assign ay_num    = ayn_reg;
    assign ay_den    = ayd_reg;

endmodule

[src/dvf_mid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvf_mid
// Viewport size from the first quotients, and operands of the scale divide.
// ----------------------------------------------------------------------------
module dvf_mid import dvf_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  front_ctx_t      in_ctx,
    input  logic [AQ_W-1:0] qx,
    input  logic [AQ_W-1:0] qy,
    output logic            out_valid,
    output back_ctx_t       out_ctx,
    output logic [BQ_W-1:0] bx_num,
    output logic [BD_W-1:0] bx_den,
    output logic [BQ_W-1:0] by_num,
    output logic [BD_W-1:0] by_den
);

    logic [AQ_W-1:0] kmin;
    logic [15:0]     k_next, fvw_next, fvh_next;
    logic            v0_reg, v1_reg;
    front_ctx_t      c0_reg;
    logic [15:0]     k_reg, fvw_reg, fvh_reg;
    logic [31:0]     pw_reg, ph_reg;
    back_ctx_t       bc_next, bc_reg;
    logic [15:0]     nx_next, ny_next, dx_next, dy_next;
    logic [15:0]     nx_reg, ny_reg, dx_reg, dy_reg;

    always_comb begin
        kmin     = (qx < qy) ? qx : qy;
        k_next   = (kmin == '0) ? 16'd1 : kmin[15:0];
        fvw_next = in_ctx.dw;
        fvh_next = in_ctx.dh;
        if (in_ctx.wide) begin
            fvw_next = (qx > AQ_W'(16'hFFFF)) ? 16'hFFFF : qx[15:0];
        end else begin
            fvh_next = (qy > AQ_W'(16'hFFFF)) ? 16'hFFFF : qy[15:0];
        end
    end

    always_comb begin
        bc_next = '{mode: c0_reg.mode, dw: c0_reg.dw, dh: c0_reg.dh, vw: '0, vh: '0};
        nx_next = 16'd1;
        ny_next = 16'd1;
        dx_next = 16'd1;
        dy_next = 16'd1;
        unique case (c0_reg.mode)
            MODE_STRETCH: begin
                bc_next.vw = c0_reg.dw;
                bc_next.vh = c0_reg.dh;
                nx_next = c0_reg.dw;
                ny_next = c0_reg.dh;
                dx_next = c0_reg.sw;
                dy_next = c0_reg.sh;
            end
            MODE_NATIVE: begin
                bc_next.vw = c0_reg.sw;
                bc_next.vh = c0_reg.sh;
            end
            MODE_INTEGER: begin
                bc_next.vw = (pw_reg > 32'h0000FFFF) ? 16'hFFFF : pw_reg[15:0];
                bc_next.vh = (ph_reg > 32'h0000FFFF) ? 16'hFFFF : ph_reg[15:0];
                nx_next = k_reg;
                ny_next = k_reg;
            end
            MODE_FIT: begin
                bc_next.vw = fvw_reg;
                bc_next.vh = fvh_reg;
                nx_next = fvw_reg;
                ny_next = fvh_reg;
                dx_next = c0_reg.sw;
                dy_next = c0_reg.sh;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (ce) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c0_reg  <= in_ctx;
            k_reg   <= k_next;
            fvw_reg <= fvw_next;
            fvh_reg <= fvh_next;
            pw_reg  <= in_ctx.sw * k_next;
            ph_reg  <= in_ctx.sh * k_next;
            bc_reg  <= bc_next;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
        end
    end

    assign out_valid = v1_reg;
    assign out_ctx   = bc_reg;
    assign bx_num    = {nx_reg, 16'd0};
    assign by_num    = {ny_reg, 16'd0};
    assign bx_den    = dx_reg;
    assign by_den    = dy_reg;

endmodule

[src/display_viewport_fit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_viewport_fit
// Centered viewport and 16.16 scale factors for a source shown on a display.
// ----------------------------------------------------------------------------
// A word enters every cycle unless the result side stalls; the pipeline is
// built from two ranks of bit-serial divider pipelines (33 stages for the aspect
// and integer quotients, 32 for the scale quotients) plus six arithmetic
// stages. A stall on the result side holds the whole pipeline in place.
module display_viewport_fit import dvf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [2:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_word,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_word
);

    logic [2:0] mode_reg, aspect_reg;
    logic       ce;

    logic            f_valid;
    front_ctx_t      f_ctx;
    logic [AQ_W-1:0] axn, ayn, qx, qy;
    logic [AD_W-1:0] axd, ayd;
    logic            ax_valid, ay_valid;
    front_ctx_t      a_ctx;
    logic            mid_valid;
    back_ctx_t       mid_ctx, b_ctx;
    logic [BQ_W-1:0] bxn, byn, sx, sy;
    logic [BD_W-1:0] bxd, byd;
    logic            bx_valid, by_valid;
    logic [16:0]     dx_diff, dy_diff, dx_half, dy_half;
    out_word_t       out_next, out_reg;
    logic            out_valid_reg;

    assign ce      = !out_valid_reg || m_ready;
    assign s_ready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_FIT;
            aspect_reg <= ASP_SOURCE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data;
                REG_ASPECT: aspect_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    dvf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .in_word   (s_word),
        .mode      (mode_reg),
        .aspect    (aspect_reg),
        .out_valid (f_valid),
        .out_ctx   (f_ctx),
        .ax_num    (axn),
        .ax_den    (axd),
        .ay_num    (ayn),
        .ay_den    (ayd)
    );

    dvf_div #(.NUM_W(AQ_W), .DEN_W(AD_W), .SIDE_W($bits(front_ctx_t))) u_div_ax (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .in_valid (f_valid), .in_num (axn), .in_den (axd), .in_side (f_ctx),
        .out_valid (ax_valid), .out_quot (qx), .out_side (a_ctx)
    );

    dvf_div #(.NUM_W(AQ_W), .DEN_W(AD_W), .SIDE_W(1)) u_div_ay (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .in_valid (f_valid), .in_num (ayn), .in_den (ayd), .in_side (f_valid),
        .out_valid (ay_valid), .out_quot (qy), .out_side ()
    );

    dvf_mid u_mid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (ax_valid && ay_valid),
        .in_ctx    (a_ctx),
        .qx        (qx),
        .qy        (qy),
        .out_valid (mid_valid),
        .out_ctx   (mid_ctx),
        .bx_num    (bxn),
        .bx_den    (bxd),
        .by_num    (byn),
        .by_den    (byd)
    );

    dvf_div #(.NUM_W(BQ_W), .DEN_W(BD_W), .SIDE_W($bits(back_ctx_t))) u_div_bx (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .in_valid (mid_valid), .in_num (bxn), .in_den (bxd), .in_side (mid_ctx),
        .out_valid (bx_valid), .out_quot (sx), .out_side (b_ctx)
    );

    dvf_div #(.NUM_W(BQ_W), .DEN_W(BD_W), .SIDE_W(1)) u_div_by (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .in_valid (mid_valid), .in_num (byn), .in_den (byd), .in_side (mid_valid),
        .out_valid (by_valid), .out_quot (sy), .out_side ()
    );

    // offsets truncate toward zero
    always_comb begin
        dx_diff = {1'b0, b_ctx.dw} - {1'b0, b_ctx.vw};
        dy_diff = {1'b0, b_ctx.dh} - {1'b0, b_ctx.vh};
        dx_half = dx_diff + {16'd0, dx_diff[16]};
        dy_half = dy_diff + {16'd0, dy_diff[16]};
        out_next = '0;
        if (b_ctx.mode >= MODE_CUSTOM) begin
            out_next.keep_previous = 1'b1;
        end else begin
            out_next.view_x      = {dx_half[16], dx_half[15:1]};
            out_next.view_y      = {dy_half[16], dy_half[15:1]};
            out_next.view_width  = b_ctx.vw;
            out_next.view_height = b_ctx.vh;
            out_next.scale_x     = sx;
            out_next.scale_y     = sy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= bx_valid && by_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

endmodule

[src/dvf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvf_checker
// Port-level checks for display_viewport_fit, bound to the top level.
// ----------------------------------------------------------------------------
module dvf_checker import dvf_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    // custom word carries nothing else
    a_keep_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.keep_previous |->
            m_word.view_x == '0 && m_word.view_y == '0 &&
            m_word.view_width == '0 && m_word.view_height == '0 &&
            m_word.scale_x == '0 && m_word.scale_y == '0)
        else $error("keep word with nonzero fields");

    // input side stalls exactly when a result word is stuck
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind display_viewport_fit dvf_checker u_dvf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
